/* hw/rtl/gcp_pkg.sv */
`default_nettype none
package gcp_pkg;

    localparam int NODES    = 256;
    localparam int HANDLE_W = 8;
    localparam int COUNT_W  = 9;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam int IN_W  = 16;
    localparam int OUT_W = 96;

    localparam logic [MODE_W-1:0] MODE_ALLOC_MANAGED   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_UNMANAGED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE            = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MARK            = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SWEEP           = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_OBJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_COLLECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJECTS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_THRESH = 2'd3;

    localparam logic [COUNT_W-1:0] RST_RUN_INTERVAL = 9'd64;
    localparam logic [COUNT_W-1:0] RST_MAX_OBJECTS  = 9'd256;
    localparam logic [COUNT_W-1:0] RST_FIRST_THRESH = 9'd64;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SW_RD  = 5'b00100,
        S_SW_CHK = 5'b01000,
        S_SW_MV  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/gcp_ram.sv */
`default_nettype none
module gcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/gc_handle_pool_mark_sweep_top.sv */
`default_nettype none
// Handle pool for a mark-and-sweep collector. Each transaction on the s_ side carries
// a mode and a handle and yields exactly one result transaction on the m_ side.
// Allocate, free and mark go through two steps: the accept step issues reads of the
// list, back-pointer and free-stack memories, and the second acts on the read data and
// writes back once the output register is free. A sweep steps through each list member,
// and the single read port of the list memory must fetch the current slot and then the
// last slot before a swap-remove of a released one. Input is held off while an item
// is at work. The memories need no clearing pass after reset.
module gc_handle_pool_mark_sweep_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // mode [2:0], handle [10:3], zero fill
    input  wire logic [gcp_pkg::IN_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // result_handle [7:0], status [9:8], collect_request [10], freed_count [19:11],
    // in_use [28:20], total_allocations [60:29], total_frees [92:61], zero fill
    output logic      [gcp_pkg::OUT_W-1:0]       m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [gcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gcp_pkg::COUNT_W-1:0]     cfg_wdata
);
    import gcp_pkg::*;

    state_t state_reg, state_next;

    logic                auto_en_reg, auto_en_next;
    logic [COUNT_W-1:0]  intv_reg, intv_next;
    logic [COUNT_W-1:0]  max_reg, max_next;
    logic [COUNT_W-1:0]  thr_reg, thr_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [COUNT_W-1:0]  fresh_reg, fresh_next;
    logic [TOTAL_W-1:0]  atot_reg, atot_next;
    logic [TOTAL_W-1:0]  ftot_reg, ftot_next;
    logic [NODES-1:0]    live_reg, live_next;
    logic [NODES-1:0]    managed_reg, managed_next;
    logic [NODES-1:0]    mark_reg, mark_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic [COUNT_W-1:0]  freed_reg, freed_next;
    logic [HANDLE_W-1:0] cur_reg, cur_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                alist_we, lpos_we, fs_we;
    logic [HANDLE_W-1:0] alist_wa, alist_wd, alist_ra, alist_rd;
    logic [HANDLE_W-1:0] lpos_wa, lpos_ra;
    logic [COUNT_W-1:0]  lpos_wd, lpos_rd;
    logic [HANDLE_W-1:0] fs_wa, fs_wd, fs_ra, fs_rd;

    logic [HANDLE_W-1:0] cnt_m1;
    logic                out_free;
    logic [COUNT_W:0]    thr_sum;
    logic [HANDLE_W-1:0] grant;
    logic                grant_ok;
    logic [STATUS_W-1:0] st;
    logic                req;
    logic [HANDLE_W-1:0] res_h;

    gcp_ram #(.WIDTH(HANDLE_W), .DEPTH(NODES)) u_alist (
        .clk(clk), .we(alist_we), .waddr(alist_wa), .wdata(alist_wd),
        .raddr(alist_ra), .rdata(alist_rd)
    );

    gcp_ram #(.WIDTH(COUNT_W), .DEPTH(NODES)) u_lpos (
        .clk(clk), .we(lpos_we), .waddr(lpos_wa), .wdata(lpos_wd),
        .raddr(lpos_ra), .rdata(lpos_rd)
    );

    gcp_ram #(.WIDTH(HANDLE_W), .DEPTH(NODES)) u_fstack (
        .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
        .raddr(fs_ra), .rdata(fs_rd)
    );

    assign cnt_m1   = HANDLE_W'(cnt_reg - COUNT_W'(1));
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Reads are issued from the accept cycle and re-issued from the latched item,
    // so the read data stays put while a result waits for the output register.
    assign alist_ra = (state_reg == S_SW_RD) ? idx_reg[HANDLE_W-1:0] : cnt_m1;
    assign lpos_ra  = (state_reg == S_IDLE) ? s_tdata[MODE_W +: HANDLE_W] : handle_reg;
    assign fs_ra    = HANDLE_W'(fcnt_reg - COUNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        auto_en_next   = auto_en_reg;
        intv_next      = intv_reg;
        max_next       = max_reg;
        thr_next       = thr_reg;
        cnt_next       = cnt_reg;
        fcnt_next      = fcnt_reg;
        fresh_next     = fresh_reg;
        atot_next      = atot_reg;
        ftot_next      = ftot_reg;
        live_next      = live_reg;
        managed_next   = managed_reg;
        mark_next      = mark_reg;
        mode_next      = mode_reg;
        handle_next    = handle_reg;
        idx_next       = idx_reg;
        freed_next     = freed_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        alist_we = 1'b0;
        alist_wa = cnt_reg[HANDLE_W-1:0];
        alist_wd = '0;
        lpos_we  = 1'b0;
        lpos_wa  = '0;
        lpos_wd  = '0;
        fs_we    = 1'b0;
        fs_wa    = fcnt_reg[HANDLE_W-1:0];
        fs_wd    = '0;
        thr_sum  = '0;
        grant    = '0;
        grant_ok = 1'b0;
        st       = ST_OK;
        req      = 1'b0;
        res_h    = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AUTO_COLLECT: auto_en_next = cfg_wdata[0];
                CFG_RUN_INTERVAL: intv_next = cfg_wdata;
                CFG_MAX_OBJECTS:  max_next = cfg_wdata;
                CFG_FIRST_THRESH: thr_next = cfg_wdata;
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next   = s_tdata[MODE_W-1:0];
                    handle_next = s_tdata[MODE_W +: HANDLE_W];
                    idx_next    = '0;
                    freed_next  = '0;
                    state_next  = (s_tdata[MODE_W-1:0] == MODE_SWEEP) ? S_SW_RD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (mode_reg == MODE_ALLOC_MANAGED || mode_reg == MODE_ALLOC_UNMANAGED)
                    begin
                        if (auto_en_reg && cnt_reg >= thr_reg)
                        begin
                            thr_sum  = {1'b0, thr_reg} + {1'b0, intv_reg};
                            thr_next = (thr_sum > {1'b0, max_reg}) ? max_reg
                                                                   : thr_sum[COUNT_W-1:0];
                            req = 1'b1;
                        end
                        if (cnt_reg >= max_reg)
                        begin
                            st = ST_NO_OBJECT;
                        end
                        else
                        begin
                            if (fcnt_reg != '0)
                            begin
                                fcnt_next = fcnt_reg - COUNT_W'(1);
                                grant     = fs_rd;
                                grant_ok  = 1'b1;
                            end
                            else if (fresh_reg < COUNT_W'(NODES))
                            begin
                                grant      = fresh_reg[HANDLE_W-1:0];
                                fresh_next = fresh_reg + COUNT_W'(1);
                                grant_ok   = 1'b1;
                            end
                            if (!grant_ok)
                            begin
                                st = ST_NO_OBJECT;
                            end
                            else
                            begin
                                live_next[grant]    = 1'b1;
                                mark_next[grant]    = 1'b0;
                                managed_next[grant] = (mode_reg == MODE_ALLOC_MANAGED);
                                if (mode_reg == MODE_ALLOC_MANAGED
                                    && cnt_reg < COUNT_W'(NODES))
                                begin
                                    alist_we = 1'b1;
                                    alist_wa = cnt_reg[HANDLE_W-1:0];
                                    alist_wd = grant;
                                    lpos_we  = 1'b1;
                                    lpos_wa  = grant;
                                    lpos_wd  = cnt_reg;
                                    cnt_next = cnt_reg + COUNT_W'(1);
                                end
                                atot_next = atot_reg + TOTAL_W'(1);
                                res_h     = grant;
                            end
                        end
                    end
                    else if (mode_reg == MODE_FREE)
                    begin
                        if (!live_reg[handle_reg])
                        begin
                            st = ST_NOT_LIVE;
                        end
                        else
                        begin
                            // Swap-remove: the last list entry moves into the freed slot.
                            if (managed_reg[handle_reg] && cnt_reg != '0 && lpos_rd < cnt_reg)
                            begin
                                alist_we = 1'b1;
                                alist_wa = lpos_rd[HANDLE_W-1:0];
                                alist_wd = alist_rd;
                                lpos_we  = 1'b1;
                                lpos_wa  = alist_rd;
                                lpos_wd  = lpos_rd;
                                cnt_next = cnt_reg - COUNT_W'(1);
                            end
                            live_next[handle_reg]    = 1'b0;
                            mark_next[handle_reg]    = 1'b0;
                            managed_next[handle_reg] = 1'b0;
                            if (fcnt_reg < COUNT_W'(NODES))
                            begin
                                fs_we     = 1'b1;
                                fs_wd     = handle_reg;
                                fcnt_next = fcnt_reg + COUNT_W'(1);
                            end
                            ftot_next = ftot_reg + TOTAL_W'(1);
                        end
                    end
                    else if (mode_reg == MODE_MARK)
                    begin
                        if (!live_reg[handle_reg])
                        begin
                            st = ST_NOT_LIVE;
                        end
                        else
                        begin
                            mark_next[handle_reg] = 1'b1;
                        end
                    end
                    out_data_next  = {3'd0, ftot_next, atot_next, cnt_next, COUNT_W'(0),
                                      req, st, res_h};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SW_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    if (out_free)
                    begin
                        out_data_next  = {3'd0, ftot_reg, atot_reg, cnt_reg, freed_reg,
                                          1'b0, ST_OK, HANDLE_W'(0)};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SW_CHK;
                end
            end
            S_SW_CHK:
            begin
                cur_next = alist_rd;
                if (mark_reg[alist_rd])
                begin
                    mark_next[alist_rd] = 1'b0;
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = S_SW_RD;
                end
                else
                begin
                    state_next = S_SW_MV;
                end
            end
            S_SW_MV:
            begin
                // The moved entry lands in the current slot and is examined next.
                alist_we = 1'b1;
                alist_wa = idx_reg[HANDLE_W-1:0];
                alist_wd = alist_rd;
                lpos_we  = 1'b1;
                lpos_wa  = alist_rd;
                lpos_wd  = idx_reg;
                cnt_next = cnt_reg - COUNT_W'(1);
                live_next[cur_reg]    = 1'b0;
                mark_next[cur_reg]    = 1'b0;
                managed_next[cur_reg] = 1'b0;
                if (fcnt_reg < COUNT_W'(NODES))
                begin
                    fs_we     = 1'b1;
                    fs_wd     = cur_reg;
                    fcnt_next = fcnt_reg + COUNT_W'(1);
                end
                ftot_next  = ftot_reg + TOTAL_W'(1);
                freed_next = freed_reg + COUNT_W'(1);
                state_next = S_SW_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            auto_en_reg   <= 1'b1;
            intv_reg      <= RST_RUN_INTERVAL;
            max_reg       <= RST_MAX_OBJECTS;
            thr_reg       <= RST_FIRST_THRESH;
            cnt_reg       <= '0;
            fcnt_reg      <= '0;
            fresh_reg     <= '0;
            atot_reg      <= '0;
            ftot_reg      <= '0;
            live_reg      <= '0;
            managed_reg   <= '0;
            mark_reg      <= '0;
            idx_reg       <= '0;
            freed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            auto_en_reg   <= auto_en_next;
            intv_reg      <= intv_next;
            max_reg       <= max_next;
            thr_reg       <= thr_next;
            cnt_reg       <= cnt_next;
            fcnt_reg      <= fcnt_next;
            fresh_reg     <= fresh_next;
            atot_reg      <= atot_next;
            ftot_reg      <= ftot_next;
            live_reg      <= live_next;
            managed_reg   <= managed_next;
            mark_reg      <= mark_next;
            idx_reg       <= idx_next;
            freed_reg     <= freed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        handle_reg   <= handle_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/gcp_checker.sv */
`default_nettype none
module gcp_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [gcp_pkg::OUT_W-1:0]       m_tdata
);
    import gcp_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The list never holds more entries than the pool has handles.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[28:20] <= 9'd256)
        else $error("in_use beyond pool size");

    // A failed item reports neither a handle nor a freed count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9:8] != ST_OK |-> m_tdata[7:0] == 8'd0 && m_tdata[19:11] == 9'd0)
        else $error("failed item reports a handle or frees");

    // Items are taken one at a time: no new input while an item is still at work
    // means the cycle after an accept never accepts again.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted back to back");

endmodule

bind gc_handle_pool_mark_sweep_top gcp_checker u_gcp_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* verif/gc_handle_pool_mark_sweep_top_test.sv */
`default_nettype none
module gc_handle_pool_mark_sweep_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gcp_pkg::*;

    // Packed from the top bit down, so result_handle lands in the lowest bits.
    typedef struct packed {
        logic [31:0] total_frees;
        logic [31:0] total_allocations;
        logic [8:0]  in_use;
        logic [8:0]  freed_count;
        logic        collect_request;
        logic [1:0]  status;
        logic [7:0]  result_handle;
    } pool_result_t;

    // One directed row; chk_status set means the status is known up front.
    typedef struct {
        logic [2:0] mode;
        logic [7:0] handle;
        bit         chk_status;
        logic [1:0] status;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;

    gc_handle_pool_mark_sweep_top dut (.*);

    always #5 clk = ~clk;

    // Predictor state for the handle pool.
    logic [7:0]  pool_list [NODES];
    logic [8:0]  pool_pos [NODES];
    logic [7:0]  pool_free [NODES];
    int unsigned list_len, free_len, fresh_next;
    bit          live [NODES];
    bit          managed [NODES];
    bit          marked [NODES];
    int unsigned threshold, allocs, frees;
    int unsigned auto_en, interval, max_obj;

    pool_result_t expected_results [$];
    logic [1:0]   status_known [$];
    bit           status_known_en [$];
    bit           failed = 1'b0;
    bit           stim_done = 1'b0;
    int           idle_cycles = 0;
    int unsigned  live_handles [$];

    function automatic void release_handle(input int unsigned h);
        int unsigned p;
        int unsigned mv;
        if (managed[h]) begin
            p = pool_pos[h];
            if (list_len > 0 && p < list_len) begin
                mv = pool_list[list_len - 1];
                pool_list[p] = 8'(mv);
                pool_pos[mv] = 9'(p);
                list_len--;
            end
        end
        live[h] = 0;
        marked[h] = 0;
        managed[h] = 0;
        if (free_len < NODES) begin
            pool_free[free_len] = 8'(h);
            free_len++;
        end
        frees++;
    endfunction

    function automatic pool_result_t pool_predict(input logic [2:0] mode, input logic [7:0] h);
        pool_result_t r;
        int unsigned g;
        int unsigned t;
        int unsigned i;
        int unsigned c;
        r = '0;
        if (mode == MODE_ALLOC_MANAGED || mode == MODE_ALLOC_UNMANAGED) begin
            if (auto_en != 0 && list_len >= threshold) begin
                t = threshold + interval;
                if (t > max_obj) t = max_obj;
                threshold = t & 9'h1FF;
                r.collect_request = 1'b1;
            end
            if (list_len >= max_obj) r.status = ST_NO_OBJECT;
            else if (free_len == 0 && fresh_next >= NODES) r.status = ST_NO_OBJECT;
            else begin
                if (free_len > 0) begin
                    free_len--;
                    g = pool_free[free_len];
                end else begin
                    g = fresh_next;
                    fresh_next++;
                end
                live[g] = 1;
                marked[g] = 0;
                managed[g] = (mode == MODE_ALLOC_MANAGED);
                if (mode == MODE_ALLOC_MANAGED) begin
                    pool_list[list_len] = 8'(g);
                    pool_pos[g] = 9'(list_len);
                    list_len++;
                end
                allocs++;
                r.result_handle = 8'(g);
            end
        end else if (mode == MODE_FREE) begin
            if (!live[h]) r.status = ST_NOT_LIVE;
            else release_handle(h);
        end else if (mode == MODE_MARK) begin
            if (!live[h]) r.status = ST_NOT_LIVE;
            else marked[h] = 1;
        end else if (mode == MODE_SWEEP) begin
            i = 0;
            while (i < list_len) begin
                c = pool_list[i];
                if (!marked[c]) begin
                    release_handle(c);
                    r.freed_count++;
                end else begin
                    marked[c] = 0;
                    i++;
                end
            end
        end
        r.in_use = 9'(list_len);
        r.total_allocations = allocs;
        r.total_frees = frees;
        return r;
    endfunction

    // tvalid stays high after an accept until the next item or a gap replaces it,
    // so it is never assigned twice in one time step.
    task automatic send_item(input logic [2:0] mode, input logic [7:0] h,
                             input bit known, input logic [1:0] st);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_results = {expected_results, pool_predict(mode, h)};
        status_known = {status_known, st};
        status_known_en = {status_known_en, known};
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, h, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_AUTO_COLLECT: auto_en = val[0];
            CFG_RUN_INTERVAL: interval = val;
            CFG_MAX_OBJECTS:  max_obj = val;
            default: threshold = val;
        endcase
    endtask

    // Pick a live handle most of the time so frees and marks reach real objects.
    function automatic logic [7:0] pick_handle();
        int unsigned k;
        k = $urandom_range(0, NODES - 1);
        if ($urandom_range(0, 4) != 0) begin
            repeat (8) begin
                if (live[k]) return 8'(k);
                k = $urandom_range(0, fresh_next == 0 ? 0 : fresh_next - 1);
            end
        end
        return 8'(k);
    endfunction

    task automatic random_phase(input int n);
        int unsigned r;
        logic [2:0] m;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 30) m = MODE_ALLOC_MANAGED;
            else if (r < 40) m = MODE_ALLOC_UNMANAGED;
            else if (r < 58) m = MODE_FREE;
            else if (r < 88) m = MODE_MARK;
            else if (r < 96) m = MODE_SWEEP;
            else m = 3'($urandom_range(5, 7));
            send_item(m, pick_handle(), 0, ST_OK);
        end
    endtask

    // Receiver side: random stalls and field-by-field checks.
    always @(posedge clk)
    begin
        pool_result_t got;
        pool_result_t exp_r;
        if (m_tvalid && m_tready) begin
            got = m_tdata[92:0];
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $realtime, got);
                failed = 1'b1;
            end else begin
                exp_r = expected_results.pop_front();
                if (status_known_en.pop_front() && status_known[0] != got.status) begin
                    $display("%0t: table status expected %0d actual %0d", $realtime,
                             status_known[0], got.status);
                    failed = 1'b1;
                end
                void'(status_known.pop_front());
                if (got.result_handle !== exp_r.result_handle)
                    begin $display("%0t: result_handle expected %0d actual %0d", $realtime,
                        exp_r.result_handle, got.result_handle); failed = 1'b1; end
                if (got.status !== exp_r.status)
                    begin $display("%0t: status expected %0d actual %0d", $realtime,
                        exp_r.status, got.status); failed = 1'b1; end
                if (got.collect_request !== exp_r.collect_request)
                    begin $display("%0t: collect_request expected %0d actual %0d", $realtime,
                        exp_r.collect_request, got.collect_request); failed = 1'b1; end
                if (got.freed_count !== exp_r.freed_count)
                    begin $display("%0t: freed_count expected %0d actual %0d", $realtime,
                        exp_r.freed_count, got.freed_count); failed = 1'b1; end
                if (got.in_use !== exp_r.in_use)
                    begin $display("%0t: in_use expected %0d actual %0d", $realtime,
                        exp_r.in_use, got.in_use); failed = 1'b1; end
                if (got.total_allocations !== exp_r.total_allocations)
                    begin $display("%0t: total_allocations expected %0d actual %0d", $realtime,
                        exp_r.total_allocations, got.total_allocations); failed = 1'b1; end
                if (got.total_frees !== exp_r.total_frees)
                    begin $display("%0t: total_frees expected %0d actual %0d", $realtime,
                        exp_r.total_frees, got.total_frees); failed = 1'b1; end
            end
        end
        if ($urandom_range(0, 49) == 0) m_tready <= 1'b0;
        else if (!m_tready && $urandom_range(0, 9) == 0) m_tready <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
            m_tready <= ($urandom_range(0, 1) == 1) ? 1'b1 : ~m_tready;
    end

    // Watchdog: ends the run with an error if neither side moves an item past the idle limit; stalls are short.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    dir_row_t dir_rows [] = '{
        '{MODE_FREE,            8'd0,   1, ST_NOT_LIVE},
        '{MODE_MARK,            8'd255, 1, ST_NOT_LIVE},
        '{MODE_SWEEP,           8'd0,   1, ST_OK},
        '{MODE_ALLOC_MANAGED,   8'd0,   1, ST_OK},
        '{MODE_ALLOC_MANAGED,   8'd255, 1, ST_OK},
        '{MODE_ALLOC_UNMANAGED, 8'd0,   1, ST_OK},
        '{MODE_ALLOC_MANAGED,   8'd0,   1, ST_OK},
        '{MODE_MARK,            8'd1,   1, ST_OK},
        '{MODE_FREE,            8'd2,   1, ST_OK},
        '{MODE_FREE,            8'd2,   1, ST_NOT_LIVE},
        '{MODE_MARK,            8'd2,   1, ST_NOT_LIVE},
        '{MODE_ALLOC_MANAGED,   8'd0,   0, ST_OK},
        '{MODE_SWEEP,           8'd0,   0, ST_OK},
        '{3'd5,                 8'd0,   1, ST_OK},
        '{3'd6,                 8'd170, 1, ST_OK},
        '{3'd7,                 8'd85,  1, ST_OK},
        '{MODE_SWEEP,           8'd0,   0, ST_OK}
    };

    initial
    begin
        auto_en = 1;
        interval = RST_RUN_INTERVAL;
        max_obj = RST_MAX_OBJECTS;
        threshold = RST_FIRST_THRESH;
        list_len = 0; free_len = 0; fresh_next = 0; allocs = 0; frees = 0;
        for (int k = 0; k < NODES; k++)
        begin
            live[k] = 0; managed[k] = 0; marked[k] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].mode, dir_rows[k].handle, dir_rows[k].chk_status,
                      dir_rows[k].status);
        random_phase(100);
        drain_and_settle();

        // Tight limits: tiny pool, threshold zero, interval one.
        write_reg(CFG_MAX_OBJECTS, 9'd1);
        write_reg(CFG_RUN_INTERVAL, 9'd1);
        write_reg(CFG_FIRST_THRESH, 9'd0);
        send_item(MODE_SWEEP, 8'd0, 0, ST_OK);
        send_item(MODE_ALLOC_MANAGED, 8'd0, 0, ST_OK);
        send_item(MODE_ALLOC_MANAGED, 8'd0, 1, ST_NO_OBJECT);
        random_phase(80);
        drain_and_settle();

        write_reg(CFG_AUTO_COLLECT, 9'd0);
        write_reg(CFG_MAX_OBJECTS, 9'd256);
        write_reg(CFG_RUN_INTERVAL, 9'd256);
        write_reg(CFG_FIRST_THRESH, 9'd256);
        // Exhaust the handle supply with unmanaged allocations.
        for (int k = 0; k < 260; k++) send_item(MODE_ALLOC_UNMANAGED, 8'hFF, 0, ST_OK);
        drain_and_settle();

        write_reg(CFG_AUTO_COLLECT, 9'd1);
        write_reg(CFG_MAX_OBJECTS, 9'd40);
        write_reg(CFG_RUN_INTERVAL, 9'd7);
        write_reg(CFG_FIRST_THRESH, 9'd5);
        // Return some handles so managed allocations and sweeps get exercised.
        for (int k = 0; k < 60; k++) send_item(MODE_FREE, 8'($urandom_range(0, 255)), 0, ST_OK);
        random_phase(150);
        drain_and_settle();

        write_reg(CFG_MAX_OBJECTS, 9'd0);
        send_item(MODE_ALLOC_MANAGED, 8'd0, 1, ST_NO_OBJECT);
        drain_and_settle();
        write_reg(CFG_MAX_OBJECTS, 9'd256);
        write_reg(CFG_RUN_INTERVAL, 9'd0);
        random_phase(100);

        drain_and_settle();
        if (failed)
            $display("TB_ERROR");
        else
            $display("TB_OK");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/gcp_pkg.sv
hw/rtl/gcp_ram.sv
hw/rtl/gc_handle_pool_mark_sweep_top.sv
hw/rtl/gcp_checker.sv
verif/gc_handle_pool_mark_sweep_top_test.sv
